FILE: src/dtf_pkg.sv
// Shared types and constants for the decimal text to fixed point converter.
package dtf_pkg;

   // ASCII codes the front end looks for
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_POINT = 8'd46;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;

   localparam int DIGIT_W    = 4;
   localparam int GUARD_BITS = 4;
   localparam int VALUE_W    = 64;

   // Powers of ten for the fraction step table
   localparam logic [63:0] POW10 [16] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
      64'd100000000000, 64'd1000000000000, 64'd10000000000000,
      64'd100000000000000, 64'd1000000000000000
   };

   // Class of one character after the front end has looked at it
   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_SEP,
      KIND_POS,
      KIND_NEG,
      KIND_BAD,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [DIGIT_W-1:0]   digit;
   } item_type;

endpackage

FILE: src/dtf_front.sv
// Front end: accept characters, classify them and hand them to the queue.
module dtf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] ch
   output logic               push_valid,
   input  logic               push_ready,
   output dtf_pkg::item_type  push_item
);

   logic at_start_ff;
   logic at_start_in;
   logic accept;
   logic [7:0] ch;

   assign ch         = req_tdata;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // Classify the character; a sign counts only as the first one
   always_comb begin
      push_item.digit = dtf_pkg::DIGIT_W'(ch - dtf_pkg::CH_ZERO);
      priority if (ch == dtf_pkg::CH_NUL) begin
         push_item.kind = dtf_pkg::KIND_END;
      end else if (at_start_ff && ch == dtf_pkg::CH_PLUS) begin
         push_item.kind = dtf_pkg::KIND_POS;
      end else if (at_start_ff && ch == dtf_pkg::CH_MINUS) begin
         push_item.kind = dtf_pkg::KIND_NEG;
      end else if (ch == dtf_pkg::CH_POINT || ch == dtf_pkg::CH_COMMA) begin
         push_item.kind = dtf_pkg::KIND_SEP;
      end else if (ch >= dtf_pkg::CH_ZERO && ch <= dtf_pkg::CH_NINE) begin
         push_item.kind = dtf_pkg::KIND_DIGIT;
      end else begin
         push_item.kind = dtf_pkg::KIND_BAD;
      end
   end

   // Track the first character of each number
   always_comb begin
      at_start_in = at_start_ff;
      if (accept) begin
         at_start_in = (ch == dtf_pkg::CH_NUL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

endmodule

FILE: src/dtf_queue.sv
// Two-entry queue of classified characters between front and back end.
module dtf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dtf_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop,
   output dtf_pkg::item_type  pop_item
);

   localparam int DEPTH = 2;

   dtf_pkg::item_type entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/dtf_back.sv
// Back end: accumulate digits, finish the number, saturate and hold the result.
module dtf_back #(
   parameter int INT_BITS        = 32,
   parameter int FRAC_BITS       = 32,
   parameter int MAX_FRAC_DIGITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  dtf_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_value,
   output logic               rsp_ovf,
   output logic               rsp_bad
);

   localparam int TOTAL = INT_BITS + FRAC_BITS;
   localparam int FW    = FRAC_BITS + dtf_pkg::GUARD_BITS;
   localparam int AW    = INT_BITS + 4;
   localparam int POS_W = $clog2(MAX_FRAC_DIGITS + 2);
   localparam int TAB   = 1 << POS_W;
   localparam logic [INT_BITS-1:0] INT_LIM   = {1'b1, {(INT_BITS-1){1'b0}}};
   localparam logic [TOTAL-1:0]    MAG_POS   = {1'b0, {(TOTAL-1){1'b1}}};
   localparam logic [TOTAL-1:0]    MAG_NEG   = {1'b1, {(TOTAL-1){1'b0}}};
   localparam logic [FW:0]         ROUND_ADD = (FW+1)'(1 << (dtf_pkg::GUARD_BITS - 1));

   // Fraction step table: floor(2^FW / 10^k), zero outside the used positions
   logic [FW-1:0] step_tab [TAB];
   for (genvar k = 0; k < TAB; k++) begin : g_step
      if (k >= 1 && k <= MAX_FRAC_DIGITS) begin : g_used
         localparam logic [63:0] STEP = (64'd1 << FW) / dtf_pkg::POW10[k];
         assign step_tab[k] = STEP[FW-1:0];
      end else begin : g_zero
         assign step_tab[k] = '0;
      end
   end

   // Accumulator state
   logic [INT_BITS-1:0] int_ff, int_in;
   logic [FW-1:0]       frac_ff, frac_in;
   logic                point_ff, point_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                neg_ff, neg_in;
   logic                ovf_ff, ovf_in;
   logic                bad_ff, bad_in;

   // Finish stage
   logic                fin_valid_ff, fin_valid_in;
   logic [TOTAL-1:0]    fin_mag_ff;
   logic                fin_neg_ff, fin_ovf_ff, fin_bad_ff;

   // Output register
   logic                out_valid_ff, out_valid_in;
   logic [63:0]         out_value_ff;
   logic                out_ovf_ff, out_bad_ff;

   logic                out_free, fin_free, fin_move, head_end, end_pop;
   logic [AW-1:0]       int_next;
   logic [FW-1:0]       frac_step;
   logic [FW:0]         frac_round;
   logic [TOTAL-1:0]    mag_now;
   logic                sat;
   logic [TOTAL-1:0]    mag_sel, val;

   assign out_free = !out_valid_ff || rsp_tready;
   assign fin_move = fin_valid_ff && out_free;
   assign fin_free = !fin_valid_ff || out_free;
   assign head_end = (q_item.kind == dtf_pkg::KIND_END);
   assign q_pop    = q_valid && (!head_end || fin_free);
   assign end_pop  = q_pop && head_end;

   // Digit arithmetic
   assign int_next  = ({4'b0, int_ff} << 3) + ({4'b0, int_ff} << 1)
                      + AW'(q_item.digit);
   assign frac_step = FW'(step_tab[pos_ff] * FW'(q_item.digit));

   // Round the fraction and join it to the integer part
   assign frac_round = ((FW+1)'(frac_ff) + ROUND_ADD) >> dtf_pkg::GUARD_BITS;
   assign mag_now    = {int_ff, {FRAC_BITS{1'b0}}} + TOTAL'(frac_round);

   // Apply one request to the accumulators
   always_comb begin
      int_in   = int_ff;
      frac_in  = frac_ff;
      point_in = point_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      bad_in   = bad_ff;
      if (q_pop) begin
         unique case (q_item.kind)
            dtf_pkg::KIND_DIGIT: begin
               if (!point_ff) begin
                  if (int_next > AW'(INT_LIM)) begin
                     int_in = INT_LIM;
                     ovf_in = 1'b1;
                  end else begin
                     int_in = int_next[INT_BITS-1:0];
                  end
               end else if (pos_ff <= POS_W'(MAX_FRAC_DIGITS)) begin
                  frac_in = frac_ff + frac_step;
                  pos_in  = pos_ff + POS_W'(1);
               end
            end
            dtf_pkg::KIND_SEP: point_in = 1'b1;
            dtf_pkg::KIND_POS: neg_in = 1'b0;
            dtf_pkg::KIND_NEG: neg_in = 1'b1;
            dtf_pkg::KIND_BAD: bad_in = 1'b1;
            dtf_pkg::KIND_END: begin
               int_in   = '0;
               frac_in  = '0;
               point_in = 1'b0;
               pos_in   = POS_W'(1);
               neg_in   = 1'b0;
               ovf_in   = 1'b0;
               bad_in   = 1'b0;
            end
            default: bad_in = bad_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff   <= '0;
         frac_ff  <= '0;
         point_ff <= 1'b0;
         pos_ff   <= POS_W'(1);
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         point_ff <= point_in;
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         bad_ff   <= bad_in;
      end
   end

   // Capture the finished magnitude on end of number
   assign fin_valid_in = end_pop || (fin_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_pop) begin
         fin_mag_ff <= mag_now;
         fin_neg_ff <= neg_ff;
         fin_ovf_ff <= ovf_ff;
         fin_bad_ff <= bad_ff;
      end
   end

   // Saturate and apply the sign
   assign sat     = fin_ovf_ff || (fin_neg_ff ? (fin_mag_ff > MAG_NEG)
                                              : (fin_mag_ff > MAG_POS));
   assign mag_sel = sat ? (fin_neg_ff ? MAG_NEG : MAG_POS) : fin_mag_ff;
   assign val     = fin_neg_ff ? (TOTAL'(0) - mag_sel) : mag_sel;

   // Hold the result until it is taken
   assign out_valid_in = fin_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_move) begin
         out_value_ff <= 64'(signed'(val));
         out_ovf_ff   <= sat;
         out_bad_ff   <= fin_bad_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_ovf    = out_ovf_ff;
   assign rsp_bad    = out_bad_ff;

endmodule

FILE: src/decimal_text_to_fixed_point_top.sv
// Top level of the decimal text to fixed point converter.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata[7:0] = ch
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[63:0] = value,
//                                              rsp_tuser[0] = overflow, [1] = bad_char
//
// One character a cycle is taken, sustained, as long as results are drained.
// A result becomes valid once its NUL has passed the queue, which is written at the
// edge that takes the NUL, then the finish stage, then the output register.
// The two-entry queue lets the front end keep taking requests while a result
// waits on rsp_tready; req_tready falls only when the queue is full.
// Synchronous reset clears all accumulators, the queue and both valid flags.
module decimal_text_to_fixed_point_top #(
   parameter int INT_BITS        = 32,
   parameter int FRAC_BITS       = 32,
   parameter int MAX_FRAC_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [1:0]  rsp_tuser    // [0] overflow, [1] bad_char
);

   localparam int TOTAL = INT_BITS + FRAC_BITS;
   localparam logic [TOTAL-1:0] MAG_POS = {1'b0, {(TOTAL-1){1'b1}}};
   localparam logic [63:0]      SAT_POS = 64'(signed'(MAG_POS));
   localparam logic [63:0]      SAT_NEG = 64'(signed'(~MAG_POS));

   dtf_pkg::item_type push_item, pop_item;
   logic push_valid, push_ready, pop_valid, pop;
   logic rsp_ovf, rsp_bad;

   dtf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   dtf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   dtf_back #(
      .INT_BITS        (INT_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_item     (pop_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_ovf    (rsp_ovf),
      .rsp_bad    (rsp_bad)
   );

   assign rsp_tuser = {rsp_bad, rsp_ovf};

`ifndef SYNTHESIS
   // No result may be pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A saturated result is exactly the most positive or most negative value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == SAT_POS || rsp_tdata == SAT_NEG)
      else $error("overflow flagged on a value that is not saturated");

   // Every result is a sign-extended value of the configured width
   a_sign_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (&rsp_tdata[63:TOTAL-1]) || !(|rsp_tdata[63:TOTAL-1]))
      else $error("result not sign-extended from its fixed-point width");
`endif

endmodule

FILE: tb/sv/tb_decimal_text_to_fixed_point_top.sv
// Self-checking testbench for the decimal text to Q32.32 fixed point converter.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point_top;

   localparam int INT_W          = 32;
   localparam int FRAC_W         = 32;
   localparam int FRAC_DIGITS    = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_CHARS    = 300;

   localparam logic [63:0] INT_LIMIT = 64'd1 << (INT_W - 1);
   localparam logic [63:0] MAX_POS   = (64'd1 << (INT_W + FRAC_W - 1)) - 64'd1;
   localparam logic [63:0] MAX_NEG   = 64'd1 << (INT_W + FRAC_W - 1);

   typedef struct packed {
      logic [31:0] int_mag;
      logic [35:0] frac_sum;
      logic        point;
      logic [3:0]  frac_idx;
      logic        neg;
      logic        first;
      logic        ovf;
      logic        bad;
   } parse_state_type;

   localparam parse_state_type PARSE_IDLE = '{
      int_mag: 32'd0, frac_sum: 36'd0, point: 1'b0, frac_idx: 4'd1,
      neg: 1'b0, first: 1'b1, ovf: 1'b0, bad: 1'b0
   };

   typedef struct {
      logic [63:0] value;
      logic        overflow;
      logic        bad_char;
   } fixed_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] value
   logic [1:0]  rsp_tuser;           // [0] overflow, [1] bad_char

   parse_state_type  text_state = PARSE_IDLE;
   fixed_result_type expected_results[$];

   int fail_count    = 0;
   int result_count  = 0;
   int sent_count    = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   decimal_text_to_fixed_point_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Count a failure, report only the first few
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endfunction

   // Advance the parser by one character, queue the value on a NUL
   function automatic void parse_char(input logic [7:0] ch);
      fixed_result_type res;
      logic [63:0]   grown;
      logic [63:0]   pow10k;
      logic [63:0]   rounded;
      logic [63:0]   mag;
      logic [3:0]    d;
      logic          was_first;
      logic          ovf;
      if (ch == dtf_pkg::CH_NUL) begin
         rounded = ({28'd0, text_state.frac_sum} + (64'd1 << (dtf_pkg::GUARD_BITS - 1)))
                   >> dtf_pkg::GUARD_BITS;
         mag = ({32'd0, text_state.int_mag} << FRAC_W) + rounded;
         ovf = text_state.ovf;
         if (!ovf) begin
            ovf = text_state.neg ? (mag > MAX_NEG) : (mag > MAX_POS);
         end
         if (ovf) begin
            mag = text_state.neg ? MAX_NEG : MAX_POS;
         end
         res.value    = text_state.neg ? (64'd0 - mag) : mag;
         res.overflow = ovf;
         res.bad_char = text_state.bad;
         expected_results.push_back(res);
         text_state = PARSE_IDLE;
      end else begin
         was_first = text_state.first;
         text_state.first = 1'b0;
         if (was_first && (ch == dtf_pkg::CH_PLUS || ch == dtf_pkg::CH_MINUS)) begin
            text_state.neg = (ch == dtf_pkg::CH_MINUS);
         end else if (ch == dtf_pkg::CH_POINT || ch == dtf_pkg::CH_COMMA) begin
            text_state.point = 1'b1;
         end else if (ch >= dtf_pkg::CH_ZERO && ch <= dtf_pkg::CH_NINE) begin
            d = 4'(ch - dtf_pkg::CH_ZERO);
            if (!text_state.point) begin
               grown = {32'd0, text_state.int_mag} * 64'd10 + {60'd0, d};
               if (grown > INT_LIMIT) begin
                  grown = INT_LIMIT;
                  text_state.ovf = 1'b1;
               end
               text_state.int_mag = grown[31:0];
            end else if (text_state.frac_idx >= 4'd1 && text_state.frac_idx <= FRAC_DIGITS) begin
               // Weight of this digit position: 2^36 / 10^k, truncated
               pow10k = 64'd1;
               for (int k = 0; k < text_state.frac_idx; k++) begin
                  pow10k = pow10k * 64'd10;
               end
               grown = {28'd0, text_state.frac_sum}
                       + {60'd0, d} * ((64'd1 << (FRAC_W + dtf_pkg::GUARD_BITS)) / pow10k);
               text_state.frac_sum = grown[35:0];
               text_state.frac_idx = text_state.frac_idx + 4'd1;
            end
         end else begin
            text_state.bad = 1'b1;
         end
      end
   endfunction

   // Predict from every accepted request
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         parse_char(req_tdata);
      end
   end

   // Compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      fixed_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d unexpected: value=%h ovf=%b bad=%b",
                                   result_count, rsp_tdata, rsp_tuser[0], rsp_tuser[1]));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_tdata !== exp_res.value || rsp_tuser[0] !== exp_res.overflow
                || rsp_tuser[1] !== exp_res.bad_char) begin
               note_failure($sformatf(
                  "result %0d: expected value=%h ovf=%b bad=%b, got value=%h ovf=%b bad=%b",
                  result_count, exp_res.value, exp_res.overflow, exp_res.bad_char,
                  rsp_tdata, rsp_tuser[0], rsp_tuser[1]));
            end
         end
      end
   end

   // Drive rsp_tready: random stalls, plus a long hold when one is asked for
   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // End the run if no handshake happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("tb_decimal_text_to_fixed_point_top: errors");
         $finish;
      end
   end

   // Offer one character, with random gaps, and hold it until accepted
   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Send a string followed by its terminating NUL
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
      send_char(dtf_pkg::CH_NUL);
   endtask

   // Drop valid, let the last request reach the predictor, then wait for every result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Build one random number: mostly well formed, some near the bound,
   // some with stray characters, some plain noise
   task automatic send_number();
      logic [7:0]  chars[$];
      logic [63:0] near;
      string       digits;
      int          pick;
      int          n;
      int          pos;
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
         case ($urandom_range(0, 3))
            0: begin
               chars.push_back(dtf_pkg::CH_PLUS);
            end
            1: begin
               chars.push_back(dtf_pkg::CH_MINUS);
            end
            default: begin
            end
         endcase
         if (pick >= 60 && pick < 75) begin
            near = $urandom_range(0, 1) ? 64'd2147483646 + 64'($urandom_range(0, 3))
                                        : {32'd0, $urandom};
            digits = $sformatf("%0d", near);
            for (int i = 0; i < digits.len(); i++) begin
               chars.push_back(digits[i]);
            end
         end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
            repeat (n) chars.push_back(8'(dtf_pkg::CH_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 9) < 7) begin
            chars.push_back($urandom_range(0, 1) ? dtf_pkg::CH_POINT : dtf_pkg::CH_COMMA);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : $urandom_range(0, 4);
            repeat (n) begin
               if (pick >= 60 && pick < 75 && $urandom_range(0, 1)) begin
                  chars.push_back(dtf_pkg::CH_NINE);
               end else begin
                  chars.push_back(8'(dtf_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
            end
         end
         // Break the sequence with stray signs, separators or other bytes
         if (pick >= 75) begin
            repeat ($urandom_range(1, 3)) begin
               pos = $urandom_range(0, chars.size());
               case ($urandom_range(0, 4))
                  0: begin
                     chars.insert(pos, dtf_pkg::CH_PLUS);
                  end
                  1: begin
                     chars.insert(pos, dtf_pkg::CH_MINUS);
                  end
                  2: begin
                     chars.insert(pos, dtf_pkg::CH_POINT);
                  end
                  3: begin
                     chars.insert(pos, dtf_pkg::CH_COMMA);
                  end
                  default: begin
                     chars.insert(pos, 8'($urandom_range(1, 255)));
                  end
               endcase
            end
         end
      end else begin
         repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
      end
      chars.push_back(dtf_pkg::CH_NUL);
      foreach (chars[i]) begin
         send_char(chars[i]);
      end
   endtask

   // Send random numbers until the character budget is spent
   task automatic run_random(input int chars);
      int start;
      start = sent_count;
      while (sent_count - start < chars) begin
         send_number();
      end
      wait_drained();
   endtask

   task automatic test_empty();
      send_char(dtf_pkg::CH_NUL);
      wait_drained();
   endtask

   // Lone minus: negative zero comes out as zero
   task automatic test_lone_sign();
      send_text("-");
      wait_drained();
   endtask

   // Top byte, misplaced signs and repeated separators
   task automatic test_misplaced_chars();
      send_char(8'hFF);
      send_text("9-.,5+");
      wait_drained();
   endtask

   // Digits past the table, which are dropped
   task automatic test_deep_fraction();
      send_text(".99999999999");
      wait_drained();
   endtask

   task automatic test_int_overflow();
      send_text("5000000000");
      wait_drained();
   endtask

   task automatic test_random_free();
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      run_random(PHASE_CHARS);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct  = 85;
      recv_stall_pct <= 0;
      run_random(PHASE_CHARS);
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct <= 85;
      run_random(PHASE_CHARS);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct  = 14;
      recv_stall_pct <= 14;
      run_random(PHASE_CHARS);
   endtask

   // Hold the receiver off while short numbers keep arriving
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      hold_asked     <= hold_asked + 1;
      repeat (30) begin
         send_char(8'(dtf_pkg::CH_ZERO + $urandom_range(0, 9)));
         send_char(dtf_pkg::CH_NUL);
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty();
      test_lone_sign();
      test_misplaced_chars();
      test_deep_fraction();
      test_int_overflow();
      test_random_free();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_backpressure();
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("tb_decimal_text_to_fixed_point_top: clean");
      end else begin
         $display("tb_decimal_text_to_fixed_point_top: errors");
      end
      $finish;
   end

endmodule
